@@ design/chbd_pkg.sv @@
// Shared types, character codes and helpers for the chunked body decoder.
package chbd_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TRAILER,
    PH_DONE,
    PH_ERROR
  } chbd_phase_t;

  // Framing characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // Per-line and per-phase control state (chunk size is kept apart, its width varies)
  typedef struct packed {
    chbd_phase_t phase;
    logic        digit_seen;
    logic        digits_closed;
    logic        in_extension;
    logic        saw_cr;
    logic        trailer_line_empty;
  } chbd_ctl_t;

  localparam chbd_ctl_t CTL_RESET = '{
    phase:              PH_SIZE,
    digit_seen:         1'b0,
    digits_closed:      1'b0,
    in_extension:       1'b0,
    saw_cr:             1'b0,
    trailer_line_empty: 1'b1
  };

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       body_done;
    logic       format_error;
  } chbd_res_t;

  // Hex digit decode: bit 4 is valid, bits 3:0 the value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/chbd_step.sv @@
// Next-state and result logic for one body byte.
module chbd_step #(
  parameter int LEN_BITS = 31
) (
  input  logic [7:0]          c_byte,
  input  logic                first,
  input  chbd_pkg::chbd_ctl_t ctl,
  input  logic [LEN_BITS-1:0] rem,
  output chbd_pkg::chbd_ctl_t ctl_nxt,
  output logic [LEN_BITS-1:0] rem_nxt,
  output chbd_pkg::chbd_res_t res
);

  chbd_pkg::chbd_ctl_t ctl_cur;
  logic [LEN_BITS-1:0] rem_cur;
  logic [LEN_BITS-1:0] rem_dec;
  logic [4:0]          hex;
  logic                pay;

  // Restart clears everything before the byte is decoded
  assign ctl_cur = first ? chbd_pkg::CTL_RESET : ctl;
  assign rem_cur = first ? '0 : rem;
  assign rem_dec = rem_cur - LEN_BITS'(1);
  assign hex     = chbd_pkg::hex_decode(c_byte);

  always_comb begin
    ctl_nxt = ctl_cur;
    rem_nxt = rem_cur;
    pay     = 1'b0;
    case (ctl_cur.phase)
      // Size line: hex digits, optional blanks, optional extension, CR LF
      chbd_pkg::PH_SIZE: begin
        if (ctl_cur.saw_cr) begin
          if (c_byte != chbd_pkg::CH_LF || !ctl_cur.digit_seen) begin
            ctl_nxt.phase = chbd_pkg::PH_ERROR;
          end else begin
            ctl_nxt.digit_seen    = 1'b0;
            ctl_nxt.digits_closed = 1'b0;
            ctl_nxt.in_extension  = 1'b0;
            ctl_nxt.saw_cr        = 1'b0;
            if (rem_cur == '0) begin
              ctl_nxt.trailer_line_empty = 1'b1;
              ctl_nxt.phase              = chbd_pkg::PH_TRAILER;
            end else begin
              ctl_nxt.phase = chbd_pkg::PH_DATA;
            end
          end
        end else if (c_byte == chbd_pkg::CH_CR) begin
          ctl_nxt.saw_cr = 1'b1;
        end else if (c_byte == chbd_pkg::CH_LF) begin
          ctl_nxt.phase = chbd_pkg::PH_ERROR;
        end else if (ctl_cur.in_extension) begin
          ctl_nxt.in_extension = 1'b1;
        end else if (c_byte == chbd_pkg::CH_SEMI) begin
          ctl_nxt.in_extension = 1'b1;
        end else if (c_byte == chbd_pkg::CH_SPACE || c_byte == chbd_pkg::CH_TAB) begin
          if (ctl_cur.digit_seen) ctl_nxt.digits_closed = 1'b1;
        end else if (!hex[4] || ctl_cur.digits_closed) begin
          ctl_nxt.phase = chbd_pkg::PH_ERROR;
        end else if (rem_cur[LEN_BITS-1 -: 4] != 4'd0) begin
          // size would not fit
          ctl_nxt.phase = chbd_pkg::PH_ERROR;
        end else begin
          rem_nxt            = {rem_cur[LEN_BITS-5:0], hex[3:0]};
          ctl_nxt.digit_seen = 1'b1;
        end
      end
      // Payload pass-through
      chbd_pkg::PH_DATA: begin
        pay     = 1'b1;
        rem_nxt = rem_dec;
        if (rem_dec == '0) ctl_nxt.phase = chbd_pkg::PH_DATA_CR;
      end
      chbd_pkg::PH_DATA_CR: begin
        ctl_nxt.phase = (c_byte == chbd_pkg::CH_CR) ? chbd_pkg::PH_DATA_LF
                                                    : chbd_pkg::PH_ERROR;
      end
      chbd_pkg::PH_DATA_LF: begin
        if (c_byte == chbd_pkg::CH_LF) begin
          ctl_nxt.digit_seen    = 1'b0;
          ctl_nxt.digits_closed = 1'b0;
          ctl_nxt.in_extension  = 1'b0;
          ctl_nxt.saw_cr        = 1'b0;
          rem_nxt               = '0;
          ctl_nxt.phase         = chbd_pkg::PH_SIZE;
        end else begin
          ctl_nxt.phase = chbd_pkg::PH_ERROR;
        end
      end
      // Trailer lines are skipped; an empty line ends the body
      chbd_pkg::PH_TRAILER: begin
        if (ctl_cur.saw_cr) begin
          if (c_byte != chbd_pkg::CH_LF) begin
            ctl_nxt.phase = chbd_pkg::PH_ERROR;
          end else begin
            ctl_nxt.saw_cr = 1'b0;
            if (ctl_cur.trailer_line_empty) ctl_nxt.phase = chbd_pkg::PH_DONE;
            else ctl_nxt.trailer_line_empty = 1'b1;
          end
        end else if (c_byte == chbd_pkg::CH_CR) begin
          ctl_nxt.saw_cr = 1'b1;
        end else if (c_byte == chbd_pkg::CH_LF) begin
          ctl_nxt.phase = chbd_pkg::PH_ERROR;
        end else begin
          ctl_nxt.trailer_line_empty = 1'b0;
        end
      end
      chbd_pkg::PH_DONE: begin
        ctl_nxt.phase = chbd_pkg::PH_DONE;
      end
      default: begin
        ctl_nxt.phase = chbd_pkg::PH_ERROR;
      end
    endcase
  end

  // Result fields
  assign res.out_byte      = pay ? c_byte : 8'd0;
  assign res.payload_valid = pay;
  assign res.body_done     = (ctl_nxt.phase == chbd_pkg::PH_DONE);
  assign res.format_error  = (ctl_nxt.phase == chbd_pkg::PH_ERROR);

endmodule

@@ design/http_chunked_body_decoder_core.sv @@
// A request is captured by the input register when accepted; its result then moves into the
// result register, with out_valid high, once that register is free (empty or taken).
// Throughput: one byte per cycle unless out_ready stalls; the decode state loop is combinational.
// The input register can still take one request while a finished result waits on out_ready.
// Reset (rst_n low, synchronous): pipeline empty, decoder in the size line phase,
// chunk size zero. in_first_of_body restarts decoding at any byte.
module http_chunked_body_decoder_core #(
  parameter int LEN_BITS = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_first_of_body,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_payload_valid,
  output logic       out_body_done,
  output logic       out_format_error
);

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_first_r;
  chbd_pkg::chbd_ctl_t ctl_r;
  chbd_pkg::chbd_ctl_t ctl_nxt;
  logic [LEN_BITS-1:0] rem_r;
  logic [LEN_BITS-1:0] rem_nxt;
  chbd_pkg::chbd_res_t res_nxt;
  chbd_pkg::chbd_res_t res_r;
  logic                out_valid_r;
  logic                out_adv;
  logic                step_fire;

  // Handshake: result register frees up when empty or taken
  assign out_adv   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_adv;
  assign step_fire = s1_valid_r && out_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r  <= in_byte;
      s1_first_r <= in_first_of_body;
    end
  end

  // Decode logic
  chbd_step #(
    .LEN_BITS (LEN_BITS)
  ) u_step (
    .c_byte  (s1_byte_r),
    .first   (s1_first_r),
    .ctl     (ctl_r),
    .rem     (rem_r),
    .ctl_nxt (ctl_nxt),
    .rem_nxt (rem_nxt),
    .res     (res_nxt)
  );

  // Decoder state, updated once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= chbd_pkg::CTL_RESET;
      rem_r <= '0;
    end else if (step_fire) begin
      ctl_r <= ctl_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = res_r.out_byte;
  assign out_payload_valid = res_r.payload_valid;
  assign out_body_done     = res_r.body_done;
  assign out_format_error  = res_r.format_error;

  // Error is sticky until a restart
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && !s1_first_r && ctl_r.phase == chbd_pkg::PH_ERROR)
      |=> (ctl_r.phase == chbd_pkg::PH_ERROR))
    else $error("error phase left without restart");

  // Payload only comes out of the data phase
  a_pay_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && res_nxt.payload_valid)
      |-> (!s1_first_r && ctl_r.phase == chbd_pkg::PH_DATA && rem_r != '0))
    else $error("payload outside data phase");

  // A payload result never carries done or error
  a_pay_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.payload_valid) |-> (!res_r.body_done && !res_r.format_error))
    else $error("payload with done or error");

  // A stalled result is not overwritten
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(res_r)))
    else $error("stalled result changed");

endmodule
